[src/sqlk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqlk_pkg
// Types, codes, keyword tables and helpers shared by the SQL keyword lexer.
// ----------------------------------------------------------------------------
package sqlk_pkg;

	localparam int MAX_LINE = 4096;
	localparam int POS_W    = 12;
	localparam logic [POS_W-1:0] POS_CAP =
		POS_W'(((MAX_LINE - 1) < 4095) ? (MAX_LINE - 1) : 4095);

	localparam int NKW      = 9;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef enum logic [4:0] {
		TK_SELECT = 5'd0,
		TK_FROM   = 5'd1,
		TK_WHERE  = 5'd2,
		TK_GROUP  = 5'd3,
		TK_BY     = 5'd4,
		TK_HAVING = 5'd5,
		TK_ORDER  = 5'd6,
		TK_ASC    = 5'd7,
		TK_DESC   = 5'd8,
		TK_EQ     = 5'd9,
		TK_TIMES  = 5'd10,
		TK_PLUS   = 5'd11,
		TK_MINUS  = 5'd12,
		TK_SLASH  = 5'd13,
		TK_COMMA  = 5'd14,
		TK_IDENT  = 5'd15,
		TK_EOF    = 5'd16,
		TK_ERROR  = 5'd17
	} token_kind_t;

	typedef enum logic [2:0] {
		MODE_START   = 3'd0,
		MODE_KEYWORD = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_DROP    = 3'd3
	} scan_mode_t;

	typedef struct packed {
		token_kind_t      kind;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] length;
	} token_t;

	typedef struct packed {
		logic   two;
		token_t first;
		token_t second;
	} token_pair_t;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v < POS_CAP) ? v + POS_W'(1) : POS_CAP;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	// Keyword whose first letter is c; found is low when none starts with c.
	function automatic logic [4:0] kw_first(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			8'h53: r = {1'b1, 4'd0};
			8'h46: r = {1'b1, 4'd1};
			8'h57: r = {1'b1, 4'd2};
			8'h47: r = {1'b1, 4'd3};
			8'h42: r = {1'b1, 4'd4};
			8'h48: r = {1'b1, 4'd5};
			8'h4F: r = {1'b1, 4'd6};
			8'h41: r = {1'b1, 4'd7};
			8'h44: r = {1'b1, 4'd8};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_rest_len(input logic [3:0] sel);
		logic [2:0] r;
		case (sel)
			4'd0: r = 3'd5;
			4'd1: r = 3'd3;
			4'd2: r = 3'd4;
			4'd3: r = 3'd4;
			4'd4: r = 3'd1;
			4'd5: r = 3'd5;
			4'd6: r = 3'd4;
			4'd7: r = 3'd2;
			4'd8: r = 3'd3;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [39:0] kw_rest(input logic [3:0] sel);
		logic [39:0] r;
		case (sel)
			4'd0: r = "ELECT";
			4'd1: r = "ROM  ";
			4'd2: r = "HERE ";
			4'd3: r = "ROUP ";
			4'd4: r = "Y    ";
			4'd5: r = "AVING";
			4'd6: r = "RDER ";
			4'd7: r = "SC   ";
			4'd8: r = "ESC  ";
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_rest_char(input logic [3:0] sel, input logic [2:0] m);
		logic [39:0] w;
		logic [7:0]  r;
		w = kw_rest(sel);
		case (m)
			3'd0: r = w[39:32];
			3'd1: r = w[31:24];
			3'd2: r = w[23:16];
			3'd3: r = w[15:8];
			3'd4: r = w[7:0];
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[src/sqlk_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqlk_lexer
// Scanner state and next-token logic: one character in, up to two tokens out.
// ----------------------------------------------------------------------------
module sqlk_lexer
	import sqlk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  ch,
	output token_pair_t      pair,
	output logic             push
);

	scan_mode_t       mode_q, mode_d;
	logic [3:0]       sel_q, sel_d;
	logic [2:0]       km_q, km_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] ws_q, ws_d;
	logic [POS_W-1:0] wl_q, wl_d;

	logic       alpha;
	logic       kw_ok;
	logic [2:0] rl;
	logic [4:0] first;
	logic       pre_v, sc_v, call_sc;
	token_t     pre, sc;

	always_comb begin
		alpha   = is_alpha(ch);
		kw_ok   = (sel_q < 4'(NKW));
		rl      = kw_rest_len(sel_q);
		first   = kw_first(ch);
		mode_d  = mode_q;
		sel_d   = sel_q;
		km_d    = km_q;
		ws_d    = ws_q;
		wl_d    = wl_q;
		pre_v   = 1'b0;
		pre     = '{kind: TK_IDENT, start: ws_q, length: wl_q};
		sc_v    = 1'b0;
		sc      = '{kind: TK_EOF, start: '0, length: '0};
		call_sc = 1'b0;

		case (mode_q)
			MODE_KEYWORD: begin
				if (kw_ok && km_q < rl && ch == kw_rest_char(sel_q, km_q)) begin
					km_d = km_q + 3'd1;
					wl_d = sat_inc(wl_q);
				end else if (kw_ok && km_q >= rl && !alpha) begin
					pre_v   = 1'b1;
					pre     = '{kind: token_kind_t'({1'b0, sel_q}), start: '0, length: '0};
					call_sc = 1'b1;
				end else if (alpha) begin
					mode_d = MODE_IDENT;
					wl_d   = sat_inc(wl_q);
				end else begin
					pre_v   = 1'b1;
					call_sc = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (alpha) begin
					wl_d = sat_inc(wl_q);
				end else begin
					pre_v   = 1'b1;
					call_sc = 1'b1;
				end
			end
			MODE_DROP: begin
				if (ch == CH_NUL) begin
					sc_v = 1'b1;
				end
			end
			default: begin
				call_sc = 1'b1;
			end
		endcase

		if (call_sc) begin
			mode_d = MODE_START;
			case (ch)
				CH_NUL: begin
					sc_v = 1'b1;
				end
				CH_SPACE: begin
				end
				CH_EQ: begin
					sc_v = 1'b1;
					sc.kind = TK_EQ;
				end
				CH_STAR: begin
					sc_v = 1'b1;
					sc.kind = TK_TIMES;
				end
				CH_PLUS: begin
					sc_v = 1'b1;
					sc.kind = TK_PLUS;
				end
				CH_MINUS: begin
					sc_v = 1'b1;
					sc.kind = TK_MINUS;
				end
				CH_SLASH: begin
					sc_v = 1'b1;
					sc.kind = TK_SLASH;
				end
				CH_COMMA: begin
					sc_v = 1'b1;
					sc.kind = TK_COMMA;
				end
				default: begin
					if (!alpha) begin
						sc_v    = 1'b1;
						sc.kind = TK_ERROR;
						mode_d  = MODE_DROP;
					end else begin
						ws_d = pos_q;
						wl_d = POS_W'(1);
						km_d = '0;
						if (first[4]) begin
							sel_d  = first[3:0];
							mode_d = MODE_KEYWORD;
						end else begin
							mode_d = MODE_IDENT;
						end
					end
				end
			endcase
		end

		if (ch == CH_NUL) begin
			mode_d = MODE_START;
			pos_d  = '0;
		end else begin
			pos_d  = sat_inc(pos_q);
		end

		pair.two    = pre_v && sc_v;
		pair.first  = pre_v ? pre : sc;
		pair.second = sc;
		push        = pre_v || sc_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			sel_q  <= '0;
			km_q   <= '0;
			pos_q  <= '0;
			ws_q   <= '0;
			wl_q   <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			sel_q  <= sel_d;
			km_q   <= km_d;
			pos_q  <= pos_d;
			ws_q   <= ws_d;
			wl_q   <= wl_d;
		end
	end

endmodule
`default_nettype wire

[src/sqlk_result_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqlk_result_queue
// Small queue of token pairs; hands out one token per output transaction.
// ----------------------------------------------------------------------------
module sqlk_result_queue
	import sqlk_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire token_pair_t       push_data,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [4:0]             token_kind,
	output logic [POS_W-1:0]       text_start,
	output logic [POS_W-1:0]       text_length,
	output logic                   last_of_run
);

	token_pair_t       entry_q [QDEPTH];
	logic [QPTR_W-1:0] head_q, tail_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              sub_q;
	logic              pop, pop_entry;
	token_pair_t       cur;
	token_t            tok;

	always_comb begin
		full        = (cnt_q == QCNT_W'(QDEPTH));
		out_valid   = (cnt_q != '0);
		cur         = entry_q[head_q];
		tok         = sub_q ? cur.second : cur.first;
		token_kind  = tok.kind;
		text_start  = tok.start;
		text_length = tok.length;
		last_of_run = !cur.two || sub_q;
		pop         = out_valid && !out_stall;
		pop_entry   = pop && last_of_run;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			sub_q  <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= tail_q + QPTR_W'(1);
			end
			if (pop) begin
				sub_q <= !last_of_run;
			end
			if (pop_entry) begin
				head_q <= head_q + QPTR_W'(1);
			end
			if (push && !pop_entry) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && pop_entry) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[src/sql_keyword_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// An accepted character is registered; its tokens are then pushed into the token queue.
// Throughput: one character per cycle unless the token queue is full; a character that
// yields two tokens uses two output transactions; the four-entry queue absorbs bursts.
// Reset (arst_n low): scanner back to token start, line position and word cleared,
// queue emptied.
// ----------------------------------------------------------------------------
// sql_keyword_tokenizer
// Streaming SQL lexer: keywords, identifiers, operators, EOF and errors.
// ----------------------------------------------------------------------------
module sql_keyword_tokenizer
	import sqlk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       token_kind,
	output logic [11:0]      text_start,
	output logic [11:0]      text_length,
	output logic             last_of_run
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        advance;
	logic        push_req;
	logic        q_full;
	token_pair_t pair;

	assign advance  = valid_s1 && !(push_req && q_full);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
		end
	end

	sqlk_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.ch     (ch_s1),
		.pair   (pair),
		.push   (push_req)
	);

	sqlk_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance && push_req),
		.push_data  (pair),
		.full       (q_full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.token_kind (token_kind),
		.text_start (text_start),
		.text_length(text_length),
		.last_of_run(last_of_run)
	);

	a_eof_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == TK_EOF || token_kind == TK_ERROR) |-> last_of_run)
		else $error("EOF or error token not last of its run");

	a_ident_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == TK_IDENT |-> text_length != '0)
		else $error("identifier with zero length");

	a_other_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != TK_IDENT |-> text_start == '0 && text_length == '0)
		else $error("non-identifier token carries text");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance && push_req |-> !q_full)
		else $error("token pushed into full queue");

endmodule
`default_nettype wire
